/* hw/rtl/est_pkg.sv */
// Shared types and constants for the event subscription table.
// Used by the top level; has no dependencies of its own.
package est_pkg;

   localparam int MODE_W = 2;
   localparam int STATUS_W = 2;
   localparam int SIG_W = 8;
   localparam int CAP_W = 5;

   localparam logic [MODE_W-1:0] MODE_SUBSCRIBE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UNSUBSCRIBE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EMIT        = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

/* hw/rtl/est_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; no package dependencies.
module est_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/event_subscription_table_unit.sv */
// Event subscription table: top level with the scan sequencer and the entry RAM.
// Depends on est_pkg and est_ram.
// Ignored requests and requests on an empty table go straight to the final state; otherwise
// the final result follows a downward one-entry-per-cycle scan of the used entries, cut short
// when a subscribe finds a free slot.
// Busy stays high until the final result is on the ports, so a new transfer is taken only after
// the previous one is through; results are never stalled.
// Reset (synchronous) empties the table and sets the capacity limit to 16.
module event_subscription_table_unit #(
   parameter int TABLE_DEPTH = 16,
   parameter int ID_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic [est_pkg::MODE_W-1:0]          req_mode,
   input  logic [ID_BITS-1:0]                  req_emitter_id,
   input  logic [est_pkg::SIG_W-1:0]           req_signal_code,
   input  logic [ID_BITS-1:0]                  req_listener_id,
   // result channel
   output logic                                rsp_valid,
   output logic [est_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_notify_valid,
   output logic [ID_BITS-1:0]                  rsp_listener_out,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]    rsp_removed_count,
   output logic                                rsp_last,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [est_pkg::CAP_W-1:0]           csr_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = 2 * ID_BITS + est_pkg::SIG_W;
   localparam int CMP_W = (CNT_W > est_pkg::CAP_W) ? CNT_W : est_pkg::CAP_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN
   } state_type;

   state_type                    state_ff, state_in;
   logic [est_pkg::CAP_W-1:0]    cap_ff, cap_in;
   logic [CNT_W-1:0]             used_ff, used_in;
   logic [est_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [ID_BITS-1:0]           em_ff, em_in;
   logic [est_pkg::SIG_W-1:0]    sig_ff, sig_in;
   logic [ID_BITS-1:0]           lis_ff, lis_in;
   logic                         ign_ff, ign_in;
   logic                         found_ff, found_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         pend_vld_ff, pend_vld_in;
   logic [ID_BITS-1:0]           pend_ff, pend_in;
   logic [IDX_W-1:0]             addr_ff, addr_in;
   logic                         issuing_ff, issuing_in;
   logic [IDX_W-1:0]             chk_ff, chk_in;
   logic                         chk_vld_ff, chk_vld_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [est_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                         rsp_notify_ff, rsp_notify_in;
   logic [ID_BITS-1:0]           rsp_lis_ff, rsp_lis_in;
   logic [CNT_W-1:0]             rsp_removed_ff, rsp_removed_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic [ENTRY_W-1:0]           wr_data;
   logic [ENTRY_W-1:0]           rd_data;

   logic [ID_BITS-1:0]           e_em;
   logic [est_pkg::SIG_W-1:0]    e_sig;
   logic [ID_BITS-1:0]           e_lis;
   logic                         emit_match;
   logic                         remove_match;
   logic                         room;
   logic [CNT_W-1:0]             used_m1;
   logic                         accept;

   est_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(addr_ff),
      .rd_data(rd_data)
   );

   assign {e_em, e_sig, e_lis} = rd_data;

   assign emit_match = ((e_em == '0) || (e_em == em_ff)) && (e_sig == sig_ff) &&
                       (e_lis != '0);
   assign remove_match = ((em_ff == '0) || (e_em == em_ff)) &&
                         ((sig_ff == '0) || (e_sig == sig_ff)) && (e_lis == lis_ff);

   // The used region may grow only while below both the limit and the depth.
   assign room = (CMP_W'(used_ff) < CMP_W'(cap_ff)) &&
                 (used_ff < CNT_W'(TABLE_DEPTH));
   assign used_m1 = used_ff - CNT_W'(1);

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      cap_in = cap_ff;
      used_in = used_ff;
      mode_in = mode_ff;
      em_in = em_ff;
      sig_in = sig_ff;
      lis_in = lis_ff;
      ign_in = ign_ff;
      found_in = found_ff;
      cnt_in = cnt_ff;
      pend_vld_in = pend_vld_ff;
      pend_in = pend_ff;
      addr_in = addr_ff;
      issuing_in = issuing_ff;
      chk_in = chk_ff;
      chk_vld_in = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_notify_in = rsp_notify_ff;
      rsp_lis_in = rsp_lis_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_last_in = rsp_last_ff;
      wr_en = 1'b0;
      wr_addr = chk_ff;
      wr_data = '0;

      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in = req_mode;
               em_in = req_emitter_id;
               sig_in = req_signal_code;
               lis_in = req_listener_id;
               found_in = 1'b0;
               cnt_in = '0;
               pend_vld_in = 1'b0;
               addr_in = used_m1[IDX_W-1:0];
               issuing_in = 1'b1;
               unique case (req_mode)
                  est_pkg::MODE_SUBSCRIBE:
                     ign_in = (req_signal_code == '0) || (req_listener_id == '0);
                  est_pkg::MODE_UNSUBSCRIBE:
                     ign_in = (req_listener_id == '0);
                  est_pkg::MODE_EMIT:
                     ign_in = (req_signal_code == '0);
                  default:
                     ign_in = 1'b1;
               endcase
               if (ign_in || (used_ff == '0)) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // Read addresses are issued one ahead of the entry being checked.
            if (issuing_ff) begin
               chk_vld_in = 1'b1;
               chk_in = addr_ff;
               if (addr_ff == '0) begin
                  issuing_in = 1'b0;
               end else begin
                  addr_in = addr_ff - IDX_W'(1);
               end
            end
            if (chk_vld_ff) begin
               unique case (mode_ff)
                  est_pkg::MODE_SUBSCRIBE: begin
                     if (e_lis == '0) begin
                        wr_en = 1'b1;
                        wr_data = {em_ff, sig_ff, lis_ff};
                        found_in = 1'b1;
                        state_in = ST_FIN;
                     end
                  end
                  est_pkg::MODE_UNSUBSCRIBE: begin
                     if (remove_match) begin
                        wr_en = 1'b1;
                        wr_data = '0;
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end
                  est_pkg::MODE_EMIT: begin
                     // A match is held back until the next one shows it was not last.
                     if (emit_match) begin
                        if (pend_vld_ff) begin
                           rsp_valid_in = 1'b1;
                           rsp_status_in = est_pkg::STATUS_DONE;
                           rsp_notify_in = 1'b1;
                           rsp_lis_in = pend_ff;
                           rsp_removed_in = '0;
                           rsp_last_in = 1'b0;
                        end
                        pend_in = e_lis;
                        pend_vld_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               if (chk_ff == '0) begin
                  state_in = ST_FIN;
               end
            end
         end

         ST_FIN: begin
            state_in = ST_IDLE;
            issuing_in = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_status_in = est_pkg::STATUS_DONE;
            rsp_notify_in = 1'b0;
            rsp_lis_in = '0;
            rsp_removed_in = '0;
            rsp_last_in = 1'b1;
            if (ign_ff) begin
               rsp_status_in = est_pkg::STATUS_IGNORED;
            end else begin
               unique case (mode_ff)
                  est_pkg::MODE_SUBSCRIBE: begin
                     if (!found_ff) begin
                        if (room) begin
                           wr_en = 1'b1;
                           wr_addr = used_ff[IDX_W-1:0];
                           wr_data = {em_ff, sig_ff, lis_ff};
                           used_in = used_ff + CNT_W'(1);
                        end else begin
                           rsp_status_in = est_pkg::STATUS_FULL;
                        end
                     end
                  end
                  est_pkg::MODE_UNSUBSCRIBE: begin
                     rsp_removed_in = cnt_ff;
                  end
                  est_pkg::MODE_EMIT: begin
                     if (pend_vld_ff) begin
                        rsp_notify_in = 1'b1;
                        rsp_lis_in = pend_ff;
                     end
                  end
                  default: begin
                     rsp_status_in = est_pkg::STATUS_IGNORED;
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff <= est_pkg::CAP_RESET;
         used_ff <= '0;
         issuing_ff <= 1'b0;
         chk_vld_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cap_ff <= cap_in;
         used_ff <= used_in;
         issuing_ff <= issuing_in;
         chk_vld_ff <= chk_vld_in;
         pend_vld_ff <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      em_ff <= em_in;
      sig_ff <= sig_in;
      lis_ff <= lis_in;
      ign_ff <= ign_in;
      found_ff <= found_in;
      cnt_ff <= cnt_in;
      pend_ff <= pend_in;
      addr_ff <= addr_in;
      chk_ff <= chk_in;
      rsp_status_ff <= rsp_status_in;
      rsp_notify_ff <= rsp_notify_in;
      rsp_lis_ff <= rsp_lis_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_notify_valid = rsp_notify_ff;
   assign rsp_listener_out = rsp_lis_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_last = rsp_last_ff;

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(TABLE_DEPTH))
      else $error("used count beyond table depth");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff != ST_IDLE))
      else $error("table write while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transfer did not raise busy");

   a_notify_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_notify_valid) |->
         ((rsp_listener_out != '0) && (rsp_status == est_pkg::STATUS_DONE)))
      else $error("notification without a listener");

   a_partial_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("non-final result after the item ended");

endmodule
